/* sv/wss_pkg.sv */
// shared sizes, codes and state type for the weighted symbol sampler
package wss_pkg;

    localparam int NUM_SYMBOLS = 128;
    localparam int COUNT_BITS  = 16;
    localparam int SYM_BITS    = $clog2(NUM_SYMBOLS);
    localparam int TOTAL_BITS  = COUNT_BITS + SYM_BITS;

    localparam int OP_BITS     = 2;
    localparam int IN_SYM_BITS = 7;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_SYM_BITS = 7;
    localparam int STATUS_BITS = 3;

    localparam int IN_BITS     = OP_BITS + IN_SYM_BITS + FRAC_BITS;
    localparam int S_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = OUT_SYM_BITS + STATUS_BITS;
    localparam int M_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
    localparam int PROD_BITS   = FRAC_BITS + TOTAL_BITS;

    typedef enum logic [OP_BITS-1:0] {
        OP_COUNT  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_IDLE   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_COUNTED   = 3'd0,
        ST_SAMPLED   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_CLEARED   = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT_UPD,
        S_SMP_MUL,
        S_SMP_SCAN,
        S_RESP
    } state_t;

endpackage

/* sv/wss_ram.sv */
// generic simple dual-port ram with registered read
module wss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/weighted_symbol_sampler.sv */
// top level of the weighted symbol sampler: sequencer, count store and scan datapath
//
// Keeps one count per symbol in a ram plus a running total. A count request reads the
// symbol's count and writes it back incremented in S_CNT_UPD, saturating at the largest
// count. A sample request scales the 16-bit fraction by the total with one multiply in
// S_SMP_MUL, then walks the counts through the ram's single read port, one symbol per
// cycle, until the running sum passes the threshold or the last symbol is reached. Every
// request ends in S_RESP, which loads the output register once it is free. Clear, unused
// opcodes, samples of an empty table and symbols beyond the table go straight to S_RESP.
// Clear is immediate: per-entry valid bits make cleared entries read as zero, so there is
// no clearing pass after reset or clear. s_tready is high whenever the sequencer is idle,
// even while a result waits in the output register.
module weighted_symbol_sampler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // opcode, symbol, random_fraction, zero pad
    input  logic [wss_pkg::S_TDATA_BITS-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // chosen_symbol, status, zero pad
    output logic [wss_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    localparam int SYM_BITS   = wss_pkg::SYM_BITS;
    localparam int COUNT_BITS = wss_pkg::COUNT_BITS;
    localparam int TOTAL_BITS = wss_pkg::TOTAL_BITS;
    localparam int FRAC_BITS  = wss_pkg::FRAC_BITS;
    localparam int PROD_BITS  = wss_pkg::PROD_BITS;
    localparam int NSYM       = wss_pkg::NUM_SYMBOLS;

    wss_pkg::opcode_t                in_op;
    logic [wss_pkg::IN_SYM_BITS-1:0] in_symbol;
    logic [FRAC_BITS-1:0]            in_frac;

    wss_pkg::state_t state_reg, state_next;

    logic [SYM_BITS-1:0]   idx_reg, idx_next;
    logic [TOTAL_BITS-1:0] run_reg, run_next;
    logic [TOTAL_BITS-1:0] thr_reg, thr_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [NSYM-1:0]       valid_reg, valid_next;
    logic [FRAC_BITS-1:0]  frac_reg, frac_next;

    logic [wss_pkg::OUT_SYM_BITS-1:0] res_sym_reg, res_sym_next;
    wss_pkg::status_t                 res_status_reg, res_status_next;

    logic                             m_tvalid_reg, m_tvalid_next;
    logic [wss_pkg::OUT_SYM_BITS-1:0] m_sym_reg, m_sym_next;
    wss_pkg::status_t                 m_status_reg, m_status_next;

    logic                  ram_we;
    logic [SYM_BITS-1:0]   ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [SYM_BITS-1:0]   ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    logic [COUNT_BITS-1:0] cnt_val;
    logic [PROD_BITS-1:0]  product;
    logic [TOTAL_BITS-1:0] run_sum;
    logic                  in_fire;
    logic                  out_free;

    assign in_op     = wss_pkg::opcode_t'(s_tdata[wss_pkg::OP_BITS-1:0]);
    assign in_symbol = s_tdata[wss_pkg::OP_BITS +: wss_pkg::IN_SYM_BITS];
    assign in_frac   = s_tdata[wss_pkg::OP_BITS + wss_pkg::IN_SYM_BITS +: FRAC_BITS];

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign cnt_val = valid_reg[idx_reg] ? ram_rdata : '0;
    assign product = PROD_BITS'(frac_reg) * PROD_BITS'(total_reg);
    assign run_sum = TOTAL_BITS'(run_reg + TOTAL_BITS'(cnt_val));

    wss_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(NSYM)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wss_pkg::S_IDLE;
            total_reg    <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        run_reg        <= run_next;
        thr_reg        <= thr_next;
        frac_reg       <= frac_next;
        res_sym_reg    <= res_sym_next;
        res_status_reg <= res_status_next;
        m_sym_reg      <= m_sym_next;
        m_status_reg   <= m_status_next;
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        thr_next        = thr_reg;
        total_next      = total_reg;
        valid_next      = valid_reg;
        frac_next       = frac_reg;
        res_sym_next    = res_sym_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_sym_next      = m_sym_reg;
        m_status_next   = m_status_reg;
        s_tready        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = COUNT_BITS'(cnt_val + 1'b1);
        ram_raddr       = SYM_BITS'(in_symbol);

        unique case (state_reg)
            wss_pkg::S_IDLE: begin
                s_tready     = 1'b1;
                res_sym_next = '0;
                idx_next     = SYM_BITS'(in_symbol);
                frac_next    = in_frac;
                if (in_fire) begin
                    unique case (in_op)
                        wss_pkg::OP_COUNT: begin
                            if (int'(in_symbol) >= NSYM) begin
                                res_status_next = wss_pkg::ST_SATURATED;
                                state_next      = wss_pkg::S_RESP;
                            end else begin
                                state_next = wss_pkg::S_CNT_UPD;
                            end
                        end
                        wss_pkg::OP_SAMPLE: begin
                            if (total_reg == '0) begin
                                res_status_next = wss_pkg::ST_EMPTY;
                                state_next      = wss_pkg::S_RESP;
                            end else begin
                                state_next = wss_pkg::S_SMP_MUL;
                            end
                        end
                        wss_pkg::OP_CLEAR: begin
                            valid_next      = '0;
                            total_next      = '0;
                            res_status_next = wss_pkg::ST_CLEARED;
                            state_next      = wss_pkg::S_RESP;
                        end
                        default: begin
                            res_status_next = wss_pkg::ST_EMPTY;
                            state_next      = wss_pkg::S_RESP;
                        end
                    endcase
                end
            end
            wss_pkg::S_CNT_UPD: begin
                if (cnt_val == '1) begin
                    res_status_next = wss_pkg::ST_SATURATED;
                end else begin
                    ram_we              = 1'b1;
                    ram_waddr           = idx_reg;
                    valid_next[idx_reg] = 1'b1;
                    total_next          = TOTAL_BITS'(total_reg + 1'b1);
                    res_status_next     = wss_pkg::ST_COUNTED;
                end
                state_next = wss_pkg::S_RESP;
            end
            wss_pkg::S_SMP_MUL: begin
                thr_next   = product[PROD_BITS-1:FRAC_BITS];
                run_next   = '0;
                idx_next   = '0;
                ram_raddr  = '0;
                state_next = wss_pkg::S_SMP_SCAN;
            end
            wss_pkg::S_SMP_SCAN: begin
                ram_raddr = SYM_BITS'(idx_reg + 1'b1);
                run_next  = run_sum;
                if (run_sum > thr_reg || idx_reg == SYM_BITS'(NSYM - 1)) begin
                    res_sym_next    = wss_pkg::OUT_SYM_BITS'(idx_reg);
                    res_status_next = wss_pkg::ST_SAMPLED;
                    state_next      = wss_pkg::S_RESP;
                end else begin
                    idx_next = SYM_BITS'(idx_reg + 1'b1);
                end
            end
            wss_pkg::S_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_sym_next    = res_sym_reg;
                    m_status_next = res_status_reg;
                    state_next    = wss_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = wss_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = wss_pkg::M_TDATA_BITS'({m_status_reg, m_sym_reg});

`ifndef ASSERT_OFF
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wss_pkg::S_SMP_SCAN) |-> (total_reg != '0))
        else $error("scan running on an empty table");

    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wss_pkg::S_SMP_SCAN) |-> (run_reg < total_reg && thr_reg < total_reg))
        else $error("running sum or threshold reached the total");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_op == wss_pkg::OP_CLEAR) |=> (total_reg == '0 && valid_reg == '0))
        else $error("clear left counts behind");

    a_resp_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wss_pkg::S_RESP && !out_free) |=> (state_reg == wss_pkg::S_RESP))
        else $error("result dropped while output register busy");
`endif

endmodule
